>>> hdl/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define DQ_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");
`define DQ_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");
`else
`define DQ_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define DQ_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

>>> hdl/dq_pkg.sv
// Shared types and constants for the double-ended queue
package dq_pkg;

    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int KEY_W    = 32;
    localparam int KIND_W   = 3;
    localparam int STAT_W   = 2;
    localparam int GRP      = 8;
    localparam int NGRP     = (DEPTH + GRP - 1) / GRP;
    localparam int OUT_BITS = KEY_W + 1 + STAT_W + CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_SEARCH     = 3'd4,
        K_CLEAR      = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic             en;
        t_kind            kind;
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

>>> hdl/dq_cell.sv
// One queue cell: holds one entry, shifts with its neighbors, compares and taps
module dq_cell
    import dq_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [KEY_W-1:0] i_left,
    input  logic [KEY_W-1:0] i_right,
    output logic [KEY_W-1:0] o_data,
    output logic [KEY_W-1:0] o_tap,
    output logic             o_match
);

    logic [KEY_W-1:0] r_data;
    logic [KEY_W-1:0] n_data;
    logic [CNT_W-1:0] w_idx;
    logic             w_full;
    logic             w_empty;
    logic             w_in_range;
    logic             w_last;
    logic             w_sel;

    assign w_idx      = CNT_W'(i_idx);
    assign w_full     = (i_ctl.count == CNT_W'(DEPTH));
    assign w_empty    = (i_ctl.count == '0);
    assign w_in_range = (w_idx < i_ctl.count);
    assign w_last     = !w_empty && (w_idx == i_ctl.count - 1'b1);

    always_comb begin
        n_data = r_data;
        w_sel  = 1'b0;
        if (i_ctl.en) begin
            case (i_ctl.kind)
                K_PUSH_FRONT: begin
                    if (!w_full) n_data = i_left;
                end
                K_PUSH_BACK: begin
                    if (!w_full && w_idx == i_ctl.count) n_data = i_ctl.key;
                end
                K_POP_FRONT: begin
                    if (!w_empty) begin
                        n_data = i_right;
                        w_sel  = (i_idx == '0);
                    end
                end
                K_POP_BACK: begin
                    w_sel = w_last;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_tap   = w_sel ? r_data : '0;
    assign o_match = i_ctl.en && (i_ctl.kind == K_SEARCH) && w_in_range
                     && (r_data == i_ctl.key);

endmodule

>>> hdl/double_ended_queue.sv
// Top level of the double-ended queue: cell row, registered reduce tree, output register
//
// Usage:
//   Slave channel s_axis: tuser carries the operation kind (0 push front, 1 push back,
//   2 pop front, 3 pop back, 4 search, 5 clear), tdata carries the value or search key.
//   Master channel m_axis: one result item per input item, in order, with the popped
//   value, search hit, status (0 ok, 1 pop on empty, 2 push on full) and occupancy.
//   Entries live in a row of cells ordered from the front; front pushes and front pops
//   shift the whole row at once, every cell compares its own entry against a search key.
//   A result passes the group tap registers and then the output register. Throughput:
//   one item per cycle while m_axis_tready is high; a two-level OR tree over the cell taps,
//   registered after each level, feeds them, and the state update completes in the accept cycle.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any item in flight.
//   When m_axis_tready is low the result holds in the output register; one more item
//   may be accepted and waits in the tree stage, after which s_axis_tready drops.
`include "double_ended_queue_macros.svh"

module double_ended_queue
    import dq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [KEY_W-1:0]  s_axis_tdata,   // [31:0] data_in
    input  logic [KIND_W-1:0] s_axis_tuser,   // [2:0] kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // [31:0] data_out, [32] found,
                                              // [34:33] status, [41:35] occupancy
);

    logic             w_accept;
    logic             w_move;
    t_kind            w_kind;
    t_cell_ctl        w_ctl;
    logic             w_full;
    logic             w_empty;
    t_status          w_status;
    logic             w_grow;
    logic             w_m_empty;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic [KEY_W-1:0] w_data  [DEPTH];
    logic [KEY_W-1:0] w_tap   [DEPTH];
    logic             w_match [DEPTH];

    logic [KEY_W-1:0] w_grp_tap   [NGRP];
    logic             w_grp_match [NGRP];
    logic [KEY_W-1:0] r_grp_tap   [NGRP];
    logic             r_grp_match [NGRP];
    t_status          r_s1_status;
    logic [CNT_W-1:0] r_s1_occ;
    logic             r_busy;

    logic [KEY_W-1:0] w_fin_tap;
    logic             w_fin_match;

    logic             r_m_valid;
    logic [KEY_W-1:0] r_m_data;
    logic             r_m_found;
    t_status          r_m_status;
    logic [CNT_W-1:0] r_m_occ;

    assign w_move        = r_busy && (!r_m_valid || m_axis_tready);
    assign s_axis_tready = !r_busy || w_move;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_kind        = t_kind'(s_axis_tuser);
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_empty       = (r_count == '0);

    assign w_ctl.en    = w_accept;
    assign w_ctl.kind  = w_kind;
    assign w_ctl.count = r_count;
    assign w_ctl.key   = s_axis_tdata;

    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        case (w_kind) inside
            K_PUSH_FRONT, K_PUSH_BACK: begin
                if (w_full) w_status = ST_FULL;
                else        n_count  = r_count + 1'b1;
            end
            K_POP_FRONT, K_POP_BACK: begin
                if (w_empty) w_status = ST_EMPTY;
                else         n_count  = r_count - 1'b1;
            end
            K_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [KEY_W-1:0] w_left;
            logic [KEY_W-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = s_axis_tdata;
            end else begin : g_mid
                assign w_left = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_end
                assign w_right = w_data[gi];
            end else begin : g_inner
                assign w_right = w_data[gi+1];
            end
            dq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_idx   (IDX_W'(gi)),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[gi]),
                .o_tap   (w_tap[gi]),
                .o_match (w_match[gi])
            );
        end
    endgenerate

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp_tap[g]   = '0;
            w_grp_match[g] = 1'b0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < DEPTH) begin
                    w_grp_tap[g]   = w_grp_tap[g] | w_tap[g * GRP + j];
                    w_grp_match[g] = w_grp_match[g] | w_match[g * GRP + j];
                end
            end
        end
    end

    always_comb begin
        w_fin_tap   = '0;
        w_fin_match = 1'b0;
        for (int g = 0; g < NGRP; g++) begin
            w_fin_tap   = w_fin_tap | r_grp_tap[g];
            w_fin_match = w_fin_match | r_grp_match[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_busy    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) r_count <= n_count;
            if (w_accept)    r_busy <= 1'b1;
            else if (w_move) r_busy <= 1'b0;
            if (w_move)             r_m_valid <= 1'b1;
            else if (m_axis_tready) r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp_tap[g]   <= w_grp_tap[g];
                r_grp_match[g] <= w_grp_match[g];
            end
            r_s1_status <= w_status;
            r_s1_occ    <= n_count;
        end
        if (w_move) begin
            r_m_data   <= w_fin_tap;
            r_m_found  <= w_fin_match;
            r_m_status <= r_s1_status;
            r_m_occ    <= r_s1_occ;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, r_m_occ, r_m_status, r_m_found,
                            r_m_data};

    assign w_grow    = w_accept && !w_full && (w_kind == K_PUSH_FRONT || w_kind == K_PUSH_BACK);
    assign w_m_empty = r_m_valid && (r_m_status == ST_EMPTY);

    `DQ_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `DQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_grow, r_count == $past(r_count) + 1'b1)
    `DQ_ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, w_m_empty, r_m_data == '0 && r_m_occ == '0)
    `DQ_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_busy && !w_move, r_busy)

endmodule
